### src/descending_sorted_list_insert_macros.svh
// Assertion macros for the descending sorted list insert block.
// Included by files that carry concurrent checks; define ASSERT_OFF to drop them.
`ifndef DESCENDING_SORTED_LIST_INSERT_MACROS_SVH
`define DESCENDING_SORTED_LIST_INSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DSLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsli assertion failed");
// next-cycle implication
`define DSLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsli assertion failed");
`else
`define DSLI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DSLI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/dsli_pkg.sv
// Shared constants for the descending sorted list insert block.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package dsli_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed result field widths
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_INDEX_W = 4;

endpackage

`default_nettype wire

### src/dsli_if.sv
// Valid/ready channel interfaces for input values and list results.
// Depends on dsli_pkg.
`default_nettype none

interface dsli_in_if #(
    parameter int DATA_WIDTH = dsli_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dsli_out_if;
    import dsli_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [OUT_VALUE_W-1:0] element_value;
    logic [OUT_INDEX_W-1:0]        element_index;
    logic                          last;
    logic                          dropped;

    modport source (output valid, output element_value, output element_index,
                    output last, output dropped, input ready);
    modport sink   (input valid, input element_value, input element_index,
                    input last, input dropped, output ready);
endinterface

`default_nettype wire

### src/dsli_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module dsli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/descending_sorted_list_insert.sv
// Descending sorted list insert: top level. Depends on dsli_pkg, dsli_if, dsli_ram.
// Each input transaction goes through ST_LOAD, then ST_PROC, which registers results at one
// per cycle unless result.ready stalls the output. A new item waits until the pass ends,
// a pass over the list RAM's single read port through one shared compare unit.
// Reset (rst_n, async, active low) empties the list; RAM contents stay unset.
`default_nettype none
`include "descending_sorted_list_insert_macros.svh"

module descending_sorted_list_insert #(
    parameter int CAPACITY   = dsli_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = dsli_pkg::DATA_WIDTH_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    dsli_in_if.sink   item,
    dsli_out_if.source result
);
    import dsli_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_PROC = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [IDX_W-1:0]             last_idx_reg, last_idx_next;
    logic                         drop_reg, drop_next;
    logic                         inserted_reg, inserted_next;
    logic signed [DATA_WIDTH-1:0] value_reg, value_next;
    logic signed [DATA_WIDTH-1:0] carry_reg, carry_next;
    logic                         out_valid_reg, out_valid_next;
    logic [OUT_VALUE_W-1:0]       out_value_reg, out_value_next;
    logic [OUT_INDEX_W-1:0]       out_index_reg, out_index_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_drop_reg, out_drop_next;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_raddr;
    logic                         ram_re;
    logic [DATA_WIDTH-1:0]        ram_rdata;
    logic signed [DATA_WIDTH-1:0] elem;
    logic signed [DATA_WIDTH-1:0] emit_val;
    logic                         step;
    logic                         is_end;
    logic                         lt;
    logic [OUT_VALUE_W+DATA_WIDTH-1:0] value_ext;
    logic [OUT_INDEX_W+IDX_W-1:0]      index_ext;

    dsli_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (emit_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign elem   = $signed(ram_rdata);
    assign step   = (state_reg == ST_PROC) && (!out_valid_reg || result.ready);
    assign is_end = (idx_reg == last_idx_reg);
    // the one compare unit: new value ranks above the stored entry
    assign lt     = (elem < value_reg);

    always_comb
    begin
        emit_val      = elem;
        ram_we        = 1'b0;
        carry_next    = carry_reg;
        inserted_next = inserted_reg;
        if (!drop_reg)
        begin
            if (is_end)
            begin
                // slot past the old tail
                emit_val = inserted_reg ? carry_reg : value_reg;
                ram_we   = step;
            end
            else if (inserted_reg)
            begin
                emit_val   = carry_reg;
                ram_we     = step;
                carry_next = step ? elem : carry_reg;
            end
            else if (lt)
            begin
                emit_val      = value_reg;
                ram_we        = step;
                carry_next    = step ? elem : carry_reg;
                inserted_next = inserted_reg | step;
            end
        end
    end

    assign value_ext = {{OUT_VALUE_W{1'b0}}, emit_val};
    assign index_ext = {{OUT_INDEX_W{1'b0}}, idx_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        drop_next      = drop_reg;
        value_next     = value_reg;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg + IDX_W'(1);
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    value_next = item.value;
                    idx_next   = '0;
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        drop_next     = 1'b1;
                        last_idx_next = IDX_W'(CAPACITY - 1);
                    end
                    else
                    begin
                        drop_next     = 1'b0;
                        last_idx_next = count_reg[IDX_W-1:0];
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = ST_PROC;
            end
            ST_PROC:
            begin
                if (step)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = value_ext[OUT_VALUE_W-1:0];
                    out_index_next = index_ext[OUT_INDEX_W-1:0];
                    out_last_next  = is_end;
                    out_drop_next  = drop_reg;
                    idx_next       = idx_reg + IDX_W'(1);
                    if (is_end)
                    begin
                        if (!drop_reg)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            drop_reg      <= 1'b0;
            inserted_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            drop_reg      <= drop_next;
            // fresh pass starts with nothing inserted
            inserted_reg  <= (state_reg == ST_IDLE) ? 1'b0 : inserted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        carry_reg     <= carry_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        out_drop_reg  <= out_drop_next;
    end

    assign item.ready           = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.element_value = out_value_reg;
    assign result.element_index = out_index_reg;
    assign result.last          = out_last_reg;
    assign result.dropped       = out_drop_reg;

    `DSLI_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `DSLI_ASSERT_IMPL(a_drop_full, clk, rst_n, result.valid && result.dropped,
                      count_reg == CNT_W'(CAPACITY))
    `DSLI_ASSERT_NEXT(a_count_inc, clk, rst_n, step && is_end && !drop_reg,
                      count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))

endmodule

`default_nettype wire
